// ----- rtl/core/kss_pkg.sv -----
// shared types and constants for the k-stacks shared store
`default_nettype none

package kss_pkg;

   localparam int NUM_STACKS = 4;
   localparam int CAPACITY   = 64;
   localparam int DATA_W     = 32;
   localparam int ID_W       = 2;
   // pointer holds a slot number or the null value CAPACITY
   localparam int PTR_W      = $clog2(CAPACITY + 1);
   localparam int ADDR_W     = $clog2(CAPACITY);
   localparam int IDX_W      = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;

   localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(CAPACITY);

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   // pointer register update from the execute cycle
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      logic [PTR_W-1:0] top;
      logic [PTR_W-1:0] free_head;
      logic             bump_mark;
   } ptr_upd_type;

endpackage

`default_nettype wire

// ----- rtl/core/kss_ram.sv -----
// generic single-write, single-read ram with registered read data
`default_nettype none

module kss_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/kss_ptrs.sv -----
// stack top pointers, free list head and link high-water mark
`default_nettype none

module kss_ptrs (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [kss_pkg::IDX_W-1:0]  sel_idx,
   input  wire kss_pkg::ptr_upd_type       upd,
   output logic      [kss_pkg::PTR_W-1:0]  top_sel,
   output logic      [kss_pkg::PTR_W-1:0]  free_head,
   output logic      [kss_pkg::PTR_W-1:0]  mark
);

   logic [kss_pkg::PTR_W-1:0] tops_ff [kss_pkg::NUM_STACKS];
   logic [kss_pkg::PTR_W-1:0] tops_in [kss_pkg::NUM_STACKS];
   logic [kss_pkg::PTR_W-1:0] free_ff, free_in;
   // slots at or above the mark were never linked and still chain to slot+1
   logic [kss_pkg::PTR_W-1:0] mark_ff, mark_in;

   always_comb begin
      tops_in = tops_ff;
      free_in = free_ff;
      mark_in = mark_ff;
      if (upd.en) begin
         tops_in[upd.idx] = upd.top;
         free_in          = upd.free_head;
         if (upd.bump_mark) begin
            mark_in = mark_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < kss_pkg::NUM_STACKS; i++) begin
            tops_ff[i] <= kss_pkg::NULL_PTR;
         end
         free_ff <= '0;
         mark_ff <= '0;
      end else begin
         tops_ff <= tops_in;
         free_ff <= free_in;
         mark_ff <= mark_in;
      end
   end

   assign top_sel   = tops_ff[sel_idx];
   assign free_head = free_ff;
   assign mark      = mark_ff;

endmodule

`default_nettype wire

// ----- rtl/core/k_stacks_shared_store_core.sv -----
// top level: several lifo stacks sharing one slot store chained through a link ram
//
// Each transaction has an accept cycle and an execute cycle: in the accept cycle the slot
// (free head for a push, stack top for a pop) is looked up and its link and data are read
// from the link and data rams; in the execute cycle the result is formed and the rams and
// pointers are written back. A new transaction is accepted in the cycle after the execute
// cycle, so no request is taken before the last one is through; the execute cycle is held
// while the previous result still waits in the output register. The link ram needs no
// clearing pass: a high-water mark marks slots never linked, which read as pointing to
// the next slot. The data ram is never cleared; only written slots are read.
`default_nettype none

module k_stacks_shared_store_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,  // stack_id[1:0], push_value[33:2], zero pad
   input  wire logic [0:0]  req_tuser,  // opcode[0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,  // pop_value[31:0]
   output logic [1:0]       rsp_tuser   // status[1:0]
);

   localparam int PTR_W  = kss_pkg::PTR_W;
   localparam int ADDR_W = kss_pkg::ADDR_W;
   localparam int DATA_W = kss_pkg::DATA_W;
   localparam int IDX_W  = kss_pkg::IDX_W;
   localparam int ID_W   = kss_pkg::ID_W;

   kss_pkg::state_type state_ff, state_in;

   kss_pkg::opcode_type op_ff, op_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [DATA_W-1:0] val_ff, val_in;
   logic [PTR_W-1:0]  slot_ff, slot_in;
   logic              fresh_ff, fresh_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;

   kss_pkg::opcode_type req_op;
   logic [ID_W-1:0]   req_id;
   logic              accept, go;
   logic [IDX_W-1:0]  sel_idx;
   logic [PTR_W-1:0]  top_sel, free_head, mark, slot_now;
   logic [PTR_W-1:0]  link_rdata, next_link, link_wdata;
   logic [DATA_W-1:0] data_rdata;
   logic              id_ok, slot_ok, ok_push, ok_pop;
   kss_pkg::ptr_upd_type upd;

   assign req_op = kss_pkg::opcode_type'(req_tuser[0]);
   assign req_id = req_tdata[ID_W-1:0];

   assign req_tready = (state_ff == kss_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign go         = (state_ff == kss_pkg::ST_EXEC) && (!rsp_valid_ff || rsp_tready);

   assign sel_idx  = (state_ff == kss_pkg::ST_IDLE) ? IDX_W'(req_id) : IDX_W'(id_ff);
   assign slot_now = (req_op == kss_pkg::OP_PUSH) ? free_head : top_sel;

   kss_ptrs u_ptrs (
      .clock     (clock),
      .reset     (reset),
      .sel_idx   (sel_idx),
      .upd       (upd),
      .top_sel   (top_sel),
      .free_head (free_head),
      .mark      (mark)
   );

   // execute cycle decisions
   always_comb begin
      id_ok     = (int'(id_ff) < kss_pkg::NUM_STACKS);
      slot_ok   = (slot_ff < kss_pkg::NULL_PTR);
      ok_push   = (op_ff == kss_pkg::OP_PUSH) && id_ok && slot_ok;
      ok_pop    = (op_ff == kss_pkg::OP_POP) && id_ok && slot_ok;
      next_link = fresh_ff ? PTR_W'(slot_ff + 1'b1) : link_rdata;
      link_wdata = (op_ff == kss_pkg::OP_PUSH) ? top_sel : free_head;

      upd.en        = go && (ok_push || ok_pop);
      upd.idx       = IDX_W'(id_ff);
      upd.top       = ok_push ? slot_ff : next_link;
      upd.free_head = ok_push ? next_link : slot_ff;
      upd.bump_mark = ok_push && fresh_ff;
   end

   kss_ram #(.WIDTH(PTR_W), .DEPTH(kss_pkg::CAPACITY)) u_link_ram (
      .clock   (clock),
      .wr_en   (upd.en),
      .wr_addr (slot_ff[ADDR_W-1:0]),
      .wr_data (link_wdata),
      .rd_en   (accept),
      .rd_addr (slot_now[ADDR_W-1:0]),
      .rd_data (link_rdata)
   );

   kss_ram #(.WIDTH(DATA_W), .DEPTH(kss_pkg::CAPACITY)) u_data_ram (
      .clock   (clock),
      .wr_en   (go && ok_push),
      .wr_addr (slot_ff[ADDR_W-1:0]),
      .wr_data (val_ff),
      .rd_en   (accept),
      .rd_addr (slot_now[ADDR_W-1:0]),
      .rd_data (data_rdata)
   );

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      id_in         = id_ff;
      val_in        = val_ff;
      slot_in       = slot_ff;
      fresh_in      = fresh_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         kss_pkg::ST_IDLE: begin
            if (accept) begin
               op_in    = req_op;
               id_in    = req_id;
               val_in   = req_tdata[ID_W +: DATA_W];
               slot_in  = slot_now;
               fresh_in = (slot_now >= mark);
               state_in = kss_pkg::ST_EXEC;
            end
         end
         kss_pkg::ST_EXEC: begin
            if (go) begin
               rsp_valid_in = 1'b1;
               if (ok_push || ok_pop) begin
                  rsp_status_in = kss_pkg::STATUS_OK;
               end else if (op_ff == kss_pkg::OP_PUSH) begin
                  rsp_status_in = kss_pkg::STATUS_FULL;
               end else begin
                  rsp_status_in = kss_pkg::STATUS_EMPTY;
               end
               if (op_ff == kss_pkg::OP_PUSH) begin
                  rsp_value_in = '0;
               end else if (ok_pop) begin
                  rsp_value_in = data_rdata;
               end else begin
                  rsp_value_in = '1;
               end
               state_in = kss_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = kss_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kss_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      id_ff         <= id_in;
      val_ff        <= val_in;
      slot_ff       <= slot_in;
      fresh_ff      <= fresh_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

`default_nettype wire
